// ----- rtl/core/rfc_pkg.sv -----
// Shared types and constants for the read-registers frame capture block.
// No dependencies; imported by every module under rtl/core.
package rfc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 4;
  localparam int unsigned TickW   = 8;
  localparam int unsigned BoardW  = 2;
  localparam int unsigned FrameLen = 15;
  // Bytes held in the shift line; the last frame byte comes straight from the word.
  localparam int unsigned HistLen = FrameLen - 1;

  localparam logic [ByteW-1:0] START_BYTE = 8'h01;
  localparam logic [ByteW-1:0] FUNC_BYTE  = 8'h03;
  localparam logic [ByteW-1:0] COUNT_BYTE = 8'd12;

  localparam logic [PosW-1:0] POS_FUNC  = 4'd1;
  localparam logic [PosW-1:0] POS_COUNT = 4'd2;
  localparam logic [PosW-1:0] POS_DONE  = 4'd15;

  localparam logic [BoardW-1:0] BOARD_RESET   = 2'd1;
  localparam logic [TickW-1:0]  TIMEOUT_RESET = 8'd5;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic {
    KIND_PORTS = 1'b0,
    KIND_POLL  = 1'b1
  } kind_t;

  typedef enum logic {
    CFG_BOARD   = 1'b0,
    CFG_TIMEOUT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    op_t              op;
    logic [ByteW-1:0] data;
  } item_t;

  typedef struct packed {
    kind_t            kind;
    logic [ByteW-1:0] port_one;
    logic [ByteW-1:0] port_two;
    logic [ByteW-1:0] port_three;
    logic [ByteW-1:0] port_four;
  } result_t;

endpackage

// ----- rtl/core/rfc_in_reg.sv -----
// Input register stage: holds one accepted word until the core consumes it.
// Depends on rfc_pkg.
module rfc_in_reg import rfc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  item_t item_in,
  input  logic  advance,
  output logic  held_valid,
  output item_t held
);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= item_in;
    end
  end

endmodule

// ----- rtl/core/rfc_frame_core.sv -----
// Frame capture state, config registers and the single-pass step logic.
// Depends on rfc_pkg.
module rfc_frame_core import rfc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  cfg_reg_t         cfg_sel,
  input  logic [ByteW-1:0] cfg_wdata,
  input  logic             fire,
  input  item_t            item,
  output logic             has_result,
  output result_t          result
);

  logic [BoardW-1:0] board;
  logic [TickW-1:0]  timeout;
  logic              receiving;
  logic              receiving_next;
  logic [PosW-1:0]   byte_position;
  logic [PosW-1:0]   byte_position_next;
  logic [TickW-1:0]  tick_count;
  logic [TickW-1:0]  tick_count_next;
  logic [TickW-1:0]  tick_inc;
  logic [PosW-1:0]   pos_inc;
  logic              bad_header;
  logic              done;
  // hist[0] is the newest byte; at completion frame offset k sits in hist[13-k]
  logic [ByteW-1:0]  hist [HistLen];

  always_ff @(posedge clk) begin
    if (rst) begin
      board   <= BOARD_RESET;
      timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_sel)
        CFG_BOARD:   board   <= cfg_wdata[BoardW-1:0];
        CFG_TIMEOUT: timeout <= cfg_wdata[TickW-1:0];
        default:     board   <= board;
      endcase
    end
  end

  assign tick_inc   = tick_count + 1'b1;
  assign pos_inc    = byte_position + 1'b1;
  assign bad_header = ((byte_position == POS_FUNC) && (item.data != FUNC_BYTE)) ||
                      ((byte_position == POS_COUNT) && (item.data != COUNT_BYTE));
  assign done       = receiving && !bad_header && (pos_inc == POS_DONE);

  always_comb begin
    receiving_next     = receiving;
    byte_position_next = byte_position;
    tick_count_next    = tick_count;
    has_result         = 1'b0;
    case (item.op)
      OP_TICK: begin
        if (!receiving) begin
          byte_position_next = '0;
          has_result         = 1'b1;
        end else if (tick_inc >= timeout) begin
          tick_count_next    = '0;
          receiving_next     = 1'b0;
          byte_position_next = '0;
        end else begin
          tick_count_next = tick_inc;
        end
      end
      default: begin
        if (receiving) begin
          if (bad_header || done) begin
            receiving_next     = 1'b0;
            byte_position_next = '0;
          end else begin
            byte_position_next = pos_inc;
          end
          has_result = done;
        end
        // position is always zero while idle, so a start lands at offset 0
        if (!receiving_next && (item.data == START_BYTE)) begin
          receiving_next     = 1'b1;
          byte_position_next = 4'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving     <= 1'b0;
      byte_position <= '0;
      tick_count    <= '0;
    end else if (fire) begin
      receiving     <= receiving_next;
      byte_position <= byte_position_next;
      tick_count    <= tick_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (item.op == OP_BYTE)) begin
      hist[0] <= item.data;
      for (int i = 1; i < HistLen; i++) begin
        hist[i] <= hist[i-1];
      end
    end
  end

  // offset k -> hist[13-k]; offset 14 is the current byte
  always_comb begin
    result.kind = KIND_PORTS;
    if (item.op == OP_TICK) begin
      result.kind       = KIND_POLL;
      result.port_one   = '0;
      result.port_two   = '0;
      result.port_three = '0;
      result.port_four  = '0;
    end else begin
      case (board)
        2'd0: begin
          result.port_one   = hist[12];
          result.port_two   = '0;        // offset wraps past the frame
          result.port_three = hist[11];
          result.port_four  = hist[13];
        end
        2'd1: begin
          result.port_one   = hist[8];
          result.port_two   = hist[10];
          result.port_three = hist[7];
          result.port_four  = hist[9];
        end
        2'd2: begin
          result.port_one   = hist[4];
          result.port_two   = hist[6];
          result.port_three = hist[3];
          result.port_four  = hist[5];
        end
        default: begin
          result.port_one   = hist[0];
          result.port_two   = hist[2];
          result.port_three = item.data;
          result.port_four  = hist[1];
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/rfc_out_reg.sv -----
// Result register: holds a finished word until the receiver takes it.
// Depends on rfc_pkg.
module rfc_out_reg import rfc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  logic    has_result,
  input  result_t result_in,
  input  logic    stall,
  output logic    held_valid,
  output result_t held
);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (advance) begin
      held_valid <= has_result;
    end else if (!stall) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      held <= result_in;
    end
  end

endmodule

// ----- rtl/core/register_frame_capture_to_ports.sv -----
// Read-registers response capture: received bytes and timer ticks in,
// output-port bytes and poll requests out.
//
// Input channel (item_valid / item_stall): one word per accepted edge,
// operation = 0 carries a received byte in rx_byte, operation = 1 is a tick.
// A frame starts with 0x01, byte 1 must be 0x03 and byte 2 must be 12;
// on the fifteenth byte four bytes picked by board_number go out as a
// port update. A tick while idle yields a poll request (ports zero); a tick
// while receiving counts toward timeout_ticks; reaching it abandons the capture.
// Output channel (result_valid / result_stall): one word per result.
// Config channel (cfg_valid / cfg_ready): cfg_index 0 = board_number,
// 1 = timeout_ticks; cfg_ready is always high. Write only while idle.
//
// Path: an accepted word enters the input register, then one step of
// compare logic fills the result register, waiting while that is full and stalled.
// Throughput: one word per cycle unless stalled; the step runs once per cycle.
// When the receiver stalls, the result register holds and the input
// register fills, after which item_stall rises; no word is lost.
// Reset (rst, synchronous): capture idle, tick count zero, board 1,
// timeout 5, both registers empty.
module register_frame_capture_to_ports import rfc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // input words
  input  logic             item_valid,
  output logic             item_stall,
  input  logic             operation,
  input  logic [ByteW-1:0] rx_byte,
  // result words
  output logic             result_valid,
  input  logic             result_stall,
  output logic             result_kind,
  output logic [ByteW-1:0] port_one,
  output logic [ByteW-1:0] port_two,
  output logic [ByteW-1:0] port_three,
  output logic [ByteW-1:0] port_four,
  // config writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [ByteW-1:0] cfg_data
);

  item_t   item_in;
  item_t   held_item;
  logic    held_valid;
  logic    advance;
  logic    has_result;
  result_t step_result;
  result_t out_word;

  assign item_in.op   = op_t'(operation);
  assign item_in.data = rx_byte;

  // the step fires when a word is held and the result slot is free or draining
  assign advance    = held_valid && (!result_valid || !result_stall);
  assign item_stall = held_valid && !advance;
  assign cfg_ready  = 1'b1;

  rfc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (item_valid && !item_stall),
    .item_in    (item_in),
    .advance    (advance),
    .held_valid (held_valid),
    .held       (held_item)
  );

  rfc_frame_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_sel    (cfg_reg_t'(cfg_index)),
    .cfg_wdata  (cfg_data),
    .fire       (advance),
    .item       (held_item),
    .has_result (has_result),
    .result     (step_result)
  );

  rfc_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .has_result (has_result),
    .result_in  (step_result),
    .stall      (result_stall),
    .held_valid (result_valid),
    .held       (out_word)
  );

  assign result_kind = out_word.kind;
  assign port_one    = out_word.port_one;
  assign port_two    = out_word.port_two;
  assign port_three  = out_word.port_three;
  assign port_four   = out_word.port_four;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for register_frame_capture_to_ports: directed and random byte/tick words,
// scoreboarded against a cycle-free capture predictor. Depends on rfc_pkg and the top RTL.
module testbench;
  import rfc_pkg::*;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #10 clk = ~clk;

  // input word channel
  logic             item_valid = 1'b0;
  logic             item_stall;
  logic             operation  = 1'b0;
  logic [ByteW-1:0] rx_byte    = '0;
  // result word channel
  logic             result_valid;
  logic             result_stall = 1'b0;
  logic             result_kind;
  logic [ByteW-1:0] port_one, port_two, port_three, port_four;
  // config channel
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_index = 1'b0;
  logic [ByteW-1:0] cfg_data  = '0;

  register_frame_capture_to_ports u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .operation    (operation),
    .rx_byte      (rx_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_kind  (result_kind),
    .port_one     (port_one),
    .port_two     (port_two),
    .port_three   (port_three),
    .port_four    (port_four),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // words waiting to be driven, and port/poll words the block owes us
  item_t   rx_items_pending[$];
  result_t port_words_due[$];
  int      item_total = 0;
  int      errs       = 0;
  int      idle_pct   = 24;   // percent of cycles each side idles
  logic    took_item;         // input word accepted at the last rising edge

  // Predictor copy of the capture state and the two config registers.
  logic [ByteW-1:0]  cap_frame [FrameLen];
  logic              cap_active = 1'b0;
  logic [PosW-1:0]   cap_pos    = '0;
  logic [TickW-1:0]  cap_ticks  = '0;
  logic [BoardW-1:0] cap_board  = BOARD_RESET;
  logic [TickW-1:0]  cap_tmo    = TIMEOUT_RESET;

  initial foreach (cap_frame[i]) cap_frame[i] = '0;

  // frame offsets past the last stored byte read as zero
  function automatic logic [ByteW-1:0] frame_at(input logic [PosW-1:0] idx);
    return (idx < FrameLen) ? cap_frame[idx] : '0;
  endfunction

  // One accepted word through the capture logic; queues the result it causes.
  task automatic capture_step(input op_t op, input logic [ByteW-1:0] b);
    logic [PosW-1:0] pos;
    logic [PosW-1:0] base;
    result_t         r;
    if (op == OP_TICK) begin
      if (!cap_active) begin
        // idle tick: poll request, ports zero, tick count untouched
        cap_pos      = '0;
        r.kind       = KIND_POLL;
        r.port_one   = '0;
        r.port_two   = '0;
        r.port_three = '0;
        r.port_four  = '0;
        port_words_due.push_back(r);
      end else begin
        cap_ticks = cap_ticks + 1'b1;
        if (cap_ticks >= cap_tmo) begin
          cap_ticks  = '0;
          cap_active = 1'b0;
          cap_pos    = '0;
        end
      end
    end else begin
      if (cap_active) begin
        pos = cap_pos;
        if (pos < FrameLen) cap_frame[pos] = b;
        if ((pos == POS_FUNC && b != FUNC_BYTE) || (pos == POS_COUNT && b != COUNT_BYTE)) begin
          cap_active = 1'b0;
          cap_pos    = '0;
        end else begin
          pos     = pos + 1'b1;
          cap_pos = pos;
          if (pos == POS_DONE) begin
            base         = {cap_board, 2'b00};
            cap_active   = 1'b0;
            cap_pos      = '0;
            r.kind       = KIND_PORTS;
            r.port_one   = frame_at(PosW'(base + 4'd1));
            r.port_two   = frame_at(PosW'(base + 4'd15));  // wraps to 15 on board zero
            r.port_three = frame_at(PosW'(base + 4'd2));
            r.port_four  = frame_at(base);
            port_words_due.push_back(r);
          end
        end
      end
      // a start byte seen while idle (also right after an abort or a
      // completed frame) opens a new capture
      if (!cap_active && b == START_BYTE) begin
        pos = cap_pos;
        if (pos < FrameLen) cap_frame[pos] = b;
        cap_active = 1'b1;
        cap_pos    = pos + 1'b1;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [ByteW-1:0] got,
                                 input logic [ByteW-1:0] want);
    $display("%0t mismatch %s: got %02h want %02h", $realtime, what, got, want);
    errs++;
  endtask

  // Monitor: checks result words, tracks config writes and accepted input
  // words at the rising edge. A result is registered only after its input
  // word is accepted, so checking before predicting in the same edge keeps the order right.
  always @(posedge clk) begin : mon
    result_t want;
    if (rst) begin
      took_item <= 1'b0;
    end else begin
      took_item <= item_valid && !item_stall;
      if (result_valid && !result_stall) begin
        if (port_words_due.size() == 0) begin
          report_mismatch("unexpected word, kind", 8'(result_kind), '0);
        end else begin
          want = port_words_due.pop_front();
          if (result_kind != want.kind)
            report_mismatch("result_kind", 8'(result_kind), 8'(want.kind));
          if (port_one != want.port_one) report_mismatch("port_one", port_one, want.port_one);
          if (port_two != want.port_two) report_mismatch("port_two", port_two, want.port_two);
          if (port_three != want.port_three)
            report_mismatch("port_three", port_three, want.port_three);
          if (port_four != want.port_four) report_mismatch("port_four", port_four, want.port_four);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BOARD) cap_board = cfg_data[BoardW-1:0];
        else cap_tmo = cfg_data;
      end
      if (item_valid && !item_stall) capture_step(op_t'(operation), rx_byte);
    end
  end

  // Driver: inputs move on the falling edge. A presented word holds until it
  // has been taken; gaps only open between words.
  always @(negedge clk) begin : drv
    item_t nxt;
    if (rst) begin
      item_valid   <= 1'b0;
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(0, 99) < idle_pct);
      if (!item_valid || took_item) begin
        if (rx_items_pending.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          nxt = rx_items_pending.pop_front();
          item_valid <= 1'b1;
          operation  <= nxt.op;
          rx_byte    <= nxt.data;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  task automatic push_item(input op_t op, input logic [ByteW-1:0] b);
    item_t it;
    it.op   = op;
    it.data = b;
    rx_items_pending.push_back(it);
    item_total++;
  endtask

  // wrong header byte: half the time a start byte, which restarts capture
  function automatic logic [ByteW-1:0] bad_header(input logic [ByteW-1:0] good);
    return $urandom_range(0, 1) ? START_BYTE : (good ^ 8'($urandom_range(1, 255)));
  endfunction

  // One response frame with random payload; some have a bad header byte,
  // some carry ticks in the middle, some end on a start byte.
  task automatic queue_frame();
    int               flavor;
    logic [ByteW-1:0] b;
    flavor = $urandom_range(0, 11);
    for (int i = 0; i < FrameLen; i++) begin
      if (i == 0) b = START_BYTE;
      else if (i == 1) b = (flavor == 0) ? bad_header(FUNC_BYTE) : FUNC_BYTE;
      else if (i == 2) b = (flavor == 1) ? bad_header(COUNT_BYTE) : COUNT_BYTE;
      else if (i == FrameLen - 1 && flavor == 2) b = START_BYTE;
      else b = 8'($urandom);
      if ($urandom_range(0, 15) == 0) push_item(OP_TICK, 8'($urandom));
      push_item(OP_BYTE, b);
    end
  endtask

  // Wait until every word is sent and answered, then past the pipeline
  // depth so that words with no result have left the block too.
  task automatic drain();
    while (rx_items_pending.size() != 0 || item_valid) @(posedge clk);
    while (port_words_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_reg_t idx, input logic [ByteW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stim
    int                phase_end;
    int                pick;
    logic [BoardW-1:0] brd;
    logic [TickW-1:0]  tmo;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, reset settings (board 1, timeout 5).
    push_item(OP_TICK, 8'hFF);                    // idle tick -> poll
    push_item(OP_BYTE, START_BYTE);
    push_item(OP_BYTE, FUNC_BYTE);
    push_item(OP_BYTE, COUNT_BYTE);
    for (int i = 3; i < FrameLen - 1; i++) push_item(OP_BYTE, i[0] ? 8'hFF : 8'h00);
    push_item(OP_BYTE, START_BYTE);               // completing byte also starts a frame
    push_item(OP_BYTE, START_BYTE);               // bad function byte that restarts
    push_item(OP_BYTE, FUNC_BYTE);
    push_item(OP_BYTE, 8'h00);                    // bad count byte, back to idle
    push_item(OP_TICK, 8'h00);                    // poll
    push_item(OP_BYTE, START_BYTE);
    repeat (5) push_item(OP_TICK, 8'h5A);         // fifth tick hits the timeout
    push_item(OP_TICK, 8'hA5);                    // idle again -> poll
    drain();

    // Random phases, each under its own register setting.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       begin brd = 2'd0; tmo = 8'd0;   end  // offset wrap, instant timeout
        1:       begin brd = 2'd3; tmo = 8'd255; end
        2:       begin brd = 2'd2; tmo = 8'd1;   end
        3:       begin brd = BOARD_RESET; tmo = TIMEOUT_RESET; end
        default: begin
          brd = 2'($urandom);
          tmo = $urandom_range(0, 1) ? 8'($urandom_range(0, 12)) : 8'($urandom);
        end
      endcase
      idle_pct = (p == 2) ? 0 : 24;               // one long stretch with no idling
      write_cfg(CFG_BOARD, {6'($urandom), brd});
      write_cfg(CFG_TIMEOUT, tmo);
      phase_end = item_total + 240;
      while (item_total < phase_end) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          queue_frame();
        end else if (pick < 9) begin
          repeat ($urandom_range(1, 6))
            push_item($urandom_range(0, 3) == 0 ? OP_TICK : OP_BYTE,
                      $urandom_range(0, 7) == 0 ? START_BYTE : 8'($urandom));
        end else begin
          repeat ($urandom_range(1, 3)) push_item(OP_TICK, 8'($urandom));
        end
      end
      drain();
    end

    if (errs == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
